// ===== rtl/core/hcbd_pkg.sv =====
// Shared types and constants for the chunked body deframer.
// No dependencies; used by every module under rtl/core.
package hcbd_pkg;

  // Parser phases of the back end.
  typedef enum logic [2:0] {
    PH_SIZE,
    PH_EXT,
    PH_HDR_LF,
    PH_DATA,
    PH_DATA_CR,
    PH_DATA_LF,
    PH_TRAILER
  } phase_t;

  // Byte classes reported on the result channel.
  localparam logic [2:0] CL_DIGIT = 3'd0;
  localparam logic [2:0] CL_EXT   = 3'd1;
  localparam logic [2:0] CL_HCRLF = 3'd2;
  localparam logic [2:0] CL_DATA  = 3'd3;
  localparam logic [2:0] CL_DCRLF = 3'd4;
  localparam logic [2:0] CL_TRAIL = 3'd5;

  // Error codes.
  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_HEX  = 2'd1;
  localparam logic [1:0] ERR_OVF  = 2'd2;
  localparam logic [1:0] ERR_CRLF = 2'd3;

  // Characters of interest.
  localparam logic [7:0] CHAR_CR   = 8'h0d;
  localparam logic [7:0] CHAR_LF   = 8'h0a;
  localparam logic [7:0] CHAR_SEMI = 8'h3b;

  // Trailer CRLF match counts.
  localparam logic [1:0] MATCH_NONE  = 2'd0;
  localparam logic [1:0] MATCH_CR    = 2'd1;
  localparam logic [1:0] MATCH_CRLF  = 2'd2;
  localparam logic [1:0] MATCH_CRLFCR = 2'd3;

  // Queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  // One classified byte as it travels from front to back.
  typedef struct packed {
    logic [7:0] data;
    logic       is_hex;
    logic [3:0] hex_val;
    logic       is_cr;
    logic       is_lf;
    logic       is_semi;
  } token_t;

endpackage

// ===== rtl/core/hcbd_front.sv =====
// Front end: takes raw bytes and classifies them into tokens.
// Depends on hcbd_pkg; feeds hcbd_queue.
module hcbd_front (
  input  logic               in_valid,
  input  logic [7:0]         in_data_byte,
  output logic               in_stall,
  input  logic               q_full,
  output logic               q_push,
  output hcbd_pkg::token_t   q_token
);

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_token.data    = in_data_byte;
    q_token.is_hex  = 1'b1;
    q_token.hex_val = 4'd0;
    case (in_data_byte) inside
      [8'h30:8'h39]: q_token.hex_val = 4'(in_data_byte - 8'h30);
      [8'h61:8'h66]: q_token.hex_val = 4'(in_data_byte - 8'h57);
      [8'h41:8'h46]: q_token.hex_val = 4'(in_data_byte - 8'h37);
      default:       q_token.is_hex  = 1'b0;
    endcase
    q_token.is_cr   = (in_data_byte == hcbd_pkg::CHAR_CR);
    q_token.is_lf   = (in_data_byte == hcbd_pkg::CHAR_LF);
    q_token.is_semi = (in_data_byte == hcbd_pkg::CHAR_SEMI);
  end

endmodule

// ===== rtl/core/hcbd_queue.sv =====
// Short token queue decoupling front and back.
// Depends on hcbd_pkg.
module hcbd_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  hcbd_pkg::token_t push_token,
  output logic             full,
  input  logic             pop,
  output hcbd_pkg::token_t pop_token,
  output logic             empty
);

  localparam int unsigned PW = hcbd_pkg::QPTR_W;

  hcbd_pkg::token_t    mem_r [hcbd_pkg::QUEUE_DEPTH];
  logic [PW-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]         count_r, count_nxt;

  assign full      = (count_r == (PW+1)'(hcbd_pkg::QUEUE_DEPTH));
  assign empty     = (count_r == '0);
  assign pop_token = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_token;
    end
  end

endmodule

// ===== rtl/core/hcbd_back.sv =====
// Back end: chunk framing state machine and registered result stage.
// Depends on hcbd_pkg; pops tokens from hcbd_queue.
module hcbd_back #(
  parameter int unsigned SIZE_BITS = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             trailers_en,
  input  logic             q_empty,
  input  hcbd_pkg::token_t q_token,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [2:0]       out_byte_class,
  output logic [7:0]       out_payload_byte,
  output logic             out_body_end,
  output logic [1:0]       out_error_code
);

  hcbd_pkg::phase_t       phase_r, phase_nxt;
  logic [SIZE_BITS-1:0]   size_r, size_nxt;
  logic [1:0]             match_r, match_nxt;
  logic [1:0]             err_r, err_nxt;
  logic                   seen_r, seen_nxt;

  logic                   valid_r;
  logic [2:0]             cls_r;
  logic [7:0]             pay_r;
  logic                   end_r;
  logic [1:0]             code_r;

  logic [2:0]             cls;
  logic [7:0]             pay;
  logic                   body_end;
  logic [1:0]             err;

  logic [SIZE_BITS-1:0]   size_dec;
  logic [SIZE_BITS-1:0]   size_shift;
  logic                   size_ovf;
  logic                   trail_done;

  assign q_pop = !q_empty && (!valid_r || !out_stall);

  assign size_dec   = size_r - {{(SIZE_BITS-1){1'b0}}, 1'b1};
  assign size_shift = {size_r[SIZE_BITS-5:0], q_token.hex_val};
  assign size_ovf   = (size_r[SIZE_BITS-1 -: 4] != 4'd0);
  assign trail_done = trailers_en ? (match_r == hcbd_pkg::MATCH_CRLFCR)
                                  : (match_r == hcbd_pkg::MATCH_CR ||
                                     match_r == hcbd_pkg::MATCH_CRLFCR);

  // Result for the token at the head of the queue.
  always_comb begin
    cls      = hcbd_pkg::CL_DIGIT;
    pay      = 8'd0;
    body_end = 1'b0;
    err      = hcbd_pkg::ERR_NONE;
    if (err_r != hcbd_pkg::ERR_NONE) begin
      err = err_r;
    end else begin
      case (phase_r)
        hcbd_pkg::PH_SIZE: begin
          if (q_token.is_hex) begin
            if (size_ovf) err = hcbd_pkg::ERR_OVF;
          end else if (!seen_r) begin
            err = hcbd_pkg::ERR_HEX;
          end else if (q_token.is_semi) begin
            cls = hcbd_pkg::CL_EXT;
          end else if (q_token.is_cr) begin
            cls = hcbd_pkg::CL_HCRLF;
          end else begin
            err = hcbd_pkg::ERR_HEX;
          end
        end
        hcbd_pkg::PH_EXT: begin
          cls = q_token.is_cr ? hcbd_pkg::CL_HCRLF : hcbd_pkg::CL_EXT;
        end
        hcbd_pkg::PH_HDR_LF: begin
          cls = hcbd_pkg::CL_HCRLF;
          if (!q_token.is_lf) err = hcbd_pkg::ERR_CRLF;
        end
        hcbd_pkg::PH_DATA: begin
          cls = hcbd_pkg::CL_DATA;
          pay = q_token.data;
        end
        hcbd_pkg::PH_DATA_CR: begin
          cls = hcbd_pkg::CL_DCRLF;
          if (!q_token.is_cr) err = hcbd_pkg::ERR_CRLF;
        end
        hcbd_pkg::PH_DATA_LF: begin
          cls = hcbd_pkg::CL_DCRLF;
          if (!q_token.is_lf) err = hcbd_pkg::ERR_CRLF;
        end
        hcbd_pkg::PH_TRAILER: begin
          cls      = hcbd_pkg::CL_TRAIL;
          body_end = q_token.is_lf && trail_done;
        end
        default: begin
          cls = hcbd_pkg::CL_DIGIT;
        end
      endcase
    end
  end

  // Next parser state.
  always_comb begin
    phase_nxt = phase_r;
    size_nxt  = size_r;
    match_nxt = match_r;
    seen_nxt  = seen_r;
    err_nxt   = (err_r != hcbd_pkg::ERR_NONE) ? err_r : err;
    if (err_r == hcbd_pkg::ERR_NONE) begin
      case (phase_r)
        hcbd_pkg::PH_SIZE: begin
          if (q_token.is_hex) begin
            if (!size_ovf) begin
              size_nxt = size_shift;
              seen_nxt = 1'b1;
            end
          end else if (seen_r && q_token.is_semi) begin
            phase_nxt = hcbd_pkg::PH_EXT;
          end else if (seen_r && q_token.is_cr) begin
            phase_nxt = hcbd_pkg::PH_HDR_LF;
          end
        end
        hcbd_pkg::PH_EXT: begin
          if (q_token.is_cr) phase_nxt = hcbd_pkg::PH_HDR_LF;
        end
        hcbd_pkg::PH_HDR_LF: begin
          if (q_token.is_lf) begin
            if (size_r == '0) begin
              phase_nxt = hcbd_pkg::PH_TRAILER;
              match_nxt = hcbd_pkg::MATCH_CRLF;
            end else begin
              phase_nxt = hcbd_pkg::PH_DATA;
            end
          end
        end
        hcbd_pkg::PH_DATA: begin
          size_nxt = size_dec;
          if (size_dec == '0) phase_nxt = hcbd_pkg::PH_DATA_CR;
        end
        hcbd_pkg::PH_DATA_CR: begin
          if (q_token.is_cr) phase_nxt = hcbd_pkg::PH_DATA_LF;
        end
        hcbd_pkg::PH_DATA_LF: begin
          if (q_token.is_lf) begin
            phase_nxt = hcbd_pkg::PH_SIZE;
            size_nxt  = '0;
            match_nxt = hcbd_pkg::MATCH_NONE;
            seen_nxt  = 1'b0;
          end
        end
        hcbd_pkg::PH_TRAILER: begin
          if (q_token.is_cr) begin
            match_nxt = (match_r == hcbd_pkg::MATCH_CRLF) ? hcbd_pkg::MATCH_CRLFCR
                                                          : hcbd_pkg::MATCH_CR;
          end else if (q_token.is_lf) begin
            if (trail_done) begin
              phase_nxt = hcbd_pkg::PH_SIZE;
              size_nxt  = '0;
              match_nxt = hcbd_pkg::MATCH_NONE;
              seen_nxt  = 1'b0;
            end else begin
              match_nxt = (match_r == hcbd_pkg::MATCH_CR) ? hcbd_pkg::MATCH_CRLF
                                                          : hcbd_pkg::MATCH_NONE;
            end
          end else begin
            match_nxt = hcbd_pkg::MATCH_NONE;
          end
        end
        default: begin
          phase_nxt = hcbd_pkg::PH_SIZE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= hcbd_pkg::PH_SIZE;
      size_r  <= '0;
      match_r <= hcbd_pkg::MATCH_NONE;
      err_r   <= hcbd_pkg::ERR_NONE;
      seen_r  <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        phase_r <= phase_nxt;
        size_r  <= size_nxt;
        match_r <= match_nxt;
        err_r   <= err_nxt;
        seen_r  <= seen_nxt;
        valid_r <= 1'b1;
      end else if (!out_stall) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cls_r  <= cls;
      pay_r  <= pay;
      end_r  <= body_end;
      code_r <= err;
    end
  end

  assign out_valid        = valid_r;
  assign out_byte_class   = cls_r;
  assign out_payload_byte = pay_r;
  assign out_body_end     = end_r;
  assign out_error_code   = code_r;

endmodule

// ===== rtl/core/http_chunked_body_deframer_core.sv =====
// Chunked transfer-coding body deframer, one body byte per request. Bytes are
// classified in the front end, pass through a four-entry queue and are parsed
// by the back end, which holds the result in an output register. Throughput is
// one byte per clock while out_stall is low. Each byte is first written into
// the queue; the parser then pops it and registers its result in the output
// register. The queue absorbs up to four bytes of output back-pressure before
// in_stall rises. The trailer mode register takes a write only while the queue
// is empty, so every queued byte is parsed under the mode it was sent with.
// After an error the block reports the latched code on every byte until
// reset; after a completed body it rearms for the next one.
// Depends on hcbd_pkg, hcbd_front, hcbd_queue and hcbd_back.
module http_chunked_body_deframer_core #(
  parameter int unsigned SIZE_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  // byte input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_byte_class,
  output logic [7:0] out_payload_byte,
  output logic       out_body_end,
  output logic [1:0] out_error_code,
  // configuration write channel (trailers_enabled)
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_trailers_enabled
);

  logic             trailers_r;
  logic             q_full;
  logic             q_empty;
  logic             q_push;
  logic             q_pop;
  hcbd_pkg::token_t push_token;
  hcbd_pkg::token_t pop_token;

  // Writable only with no bytes waiting for the parser.
  assign cfg_ready = q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trailers_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      trailers_r <= cfg_trailers_enabled;
    end
  end

  // Front: classify the byte (hex digit value, CR, LF, semicolon).
  hcbd_front u_front (
    .in_valid     (in_valid),
    .in_data_byte (in_data_byte),
    .in_stall     (in_stall),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_token      (push_token)
  );

  // Token queue between front and back.
  hcbd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_token (push_token),
    .full       (q_full),
    .pop        (q_pop),
    .pop_token  (pop_token),
    .empty      (q_empty)
  );

  // Back: framing state machine plus output register.
  hcbd_back #(
    .SIZE_BITS (SIZE_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .trailers_en      (trailers_r),
    .q_empty          (q_empty),
    .q_token          (pop_token),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte_class   (out_byte_class),
    .out_payload_byte (out_payload_byte),
    .out_body_end     (out_body_end),
    .out_error_code   (out_error_code)
  );

  // End of body only ever lands on a clean trailer byte.
  a_end_is_trailer: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_body_end) |->
      (out_byte_class == hcbd_pkg::CL_TRAIL && out_error_code == hcbd_pkg::ERR_NONE))
    else $error("body_end on non-trailer or erroring byte");

  // Payload pass-through is zero except on payload bytes.
  a_pay_only_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_byte_class != hcbd_pkg::CL_DATA) |-> (out_payload_byte == 8'd0))
    else $error("payload byte nonzero outside payload class");

  // A latched error keeps reporting on the next result.
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_error_code != hcbd_pkg::ERR_NONE) ##1 out_valid
      |-> (out_error_code == $past(out_error_code)))
    else $error("error code changed after being latched");

  // The queue never pops when it has nothing.
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_empty |-> !q_pop)
    else $error("queue popped while empty");

endmodule

// ===== tb/hcbd_deframe_checker.sv =====
// Result checker for the chunked body deframer: predicts each byte's result.
// Compares every result against the oldest prediction and counts mismatches.
// Depends on hcbd_pkg; instantiated by tb_http_chunked_body_deframer_core.
`timescale 1ns / 1ps

module hcbd_deframe_checker #(
  parameter int unsigned SIZE_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [2:0] out_byte_class,
  input  logic [7:0] out_payload_byte,
  input  logic       out_body_end,
  input  logic [1:0] out_error_code,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic       cfg_trailers_enabled,
  input  logic       end_check,
  output int         pending_cnt,
  output int         fail_count
);

  typedef struct packed {
    logic [2:0] byte_class;
    logic [7:0] payload_byte;
    logic       body_end;
    logic [1:0] error_code;
  } deframe_result_t;

  deframe_result_t expected_q[$];

  // predictor state
  hcbd_pkg::phase_t     parse_phase;
  logic [SIZE_BITS-1:0] chunk_left;
  logic [1:0]           crlf_seen;
  logic [1:0]           sticky_err;
  logic                 size_digit_seen;
  logic                 trailers_on;

  initial begin
    pending_cnt = 0;
    fail_count  = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    fail_count++;
  endtask

  task automatic rearm_parser();
    parse_phase     = hcbd_pkg::PH_SIZE;
    chunk_left      = '0;
    crlf_seen       = hcbd_pkg::MATCH_NONE;
    size_digit_seen = 1'b0;
  endtask

  task automatic deframe_step(input logic [7:0] b, output deframe_result_t r);
    logic       is_digit;
    logic [3:0] digit;
    logic [1:0] c;
    logic       done;
    r = '0;
    r.byte_class = hcbd_pkg::CL_DIGIT;
    if (sticky_err != hcbd_pkg::ERR_NONE) begin
      r.error_code = sticky_err;
      return;
    end
    is_digit = 1'b1;
    digit    = b[3:0];
    if (b >= "a" && b <= "f" || b >= "A" && b <= "F") begin
      digit = b[3:0] + 4'd9;
    end else if (!(b >= "0" && b <= "9")) begin
      is_digit = 1'b0;
    end
    case (parse_phase)
      hcbd_pkg::PH_SIZE: begin
        if (is_digit) begin
          if (chunk_left[SIZE_BITS-1 -: 4] != 4'd0) begin
            r.error_code = hcbd_pkg::ERR_OVF;
          end else begin
            chunk_left      = {chunk_left[SIZE_BITS-5:0], digit};
            size_digit_seen = 1'b1;
          end
        end else if (!size_digit_seen) begin
          r.error_code = hcbd_pkg::ERR_HEX;
        end else if (b == hcbd_pkg::CHAR_SEMI) begin
          r.byte_class = hcbd_pkg::CL_EXT;
          parse_phase  = hcbd_pkg::PH_EXT;
        end else if (b == hcbd_pkg::CHAR_CR) begin
          r.byte_class = hcbd_pkg::CL_HCRLF;
          parse_phase  = hcbd_pkg::PH_HDR_LF;
        end else begin
          r.error_code = hcbd_pkg::ERR_HEX;
        end
      end
      hcbd_pkg::PH_EXT: begin
        if (b == hcbd_pkg::CHAR_CR) begin
          r.byte_class = hcbd_pkg::CL_HCRLF;
          parse_phase  = hcbd_pkg::PH_HDR_LF;
        end else begin
          r.byte_class = hcbd_pkg::CL_EXT;
        end
      end
      hcbd_pkg::PH_HDR_LF: begin
        r.byte_class = hcbd_pkg::CL_HCRLF;
        if (b != hcbd_pkg::CHAR_LF) begin
          r.error_code = hcbd_pkg::ERR_CRLF;
        end else if (chunk_left == '0) begin
          parse_phase = hcbd_pkg::PH_TRAILER;
          crlf_seen   = hcbd_pkg::MATCH_CRLF;
        end else begin
          parse_phase = hcbd_pkg::PH_DATA;
        end
      end
      hcbd_pkg::PH_DATA: begin
        r.byte_class   = hcbd_pkg::CL_DATA;
        r.payload_byte = b;
        chunk_left     = chunk_left - 1'b1;
        if (chunk_left == '0) parse_phase = hcbd_pkg::PH_DATA_CR;
      end
      hcbd_pkg::PH_DATA_CR: begin
        r.byte_class = hcbd_pkg::CL_DCRLF;
        if (b == hcbd_pkg::CHAR_CR) parse_phase = hcbd_pkg::PH_DATA_LF;
        else r.error_code = hcbd_pkg::ERR_CRLF;
      end
      hcbd_pkg::PH_DATA_LF: begin
        r.byte_class = hcbd_pkg::CL_DCRLF;
        if (b == hcbd_pkg::CHAR_LF) rearm_parser();
        else r.error_code = hcbd_pkg::ERR_CRLF;
      end
      default: begin
        c = crlf_seen;
        r.byte_class = hcbd_pkg::CL_TRAIL;
        if (b == hcbd_pkg::CHAR_CR) begin
          crlf_seen = (c == hcbd_pkg::MATCH_CRLF) ? hcbd_pkg::MATCH_CRLFCR
                                                  : hcbd_pkg::MATCH_CR;
        end else if (b == hcbd_pkg::CHAR_LF) begin
          // with trailers on only an empty line ends the body
          done = trailers_on ? (c == hcbd_pkg::MATCH_CRLFCR)
                             : (c == hcbd_pkg::MATCH_CR || c == hcbd_pkg::MATCH_CRLFCR);
          if (done) begin
            r.body_end = 1'b1;
            rearm_parser();
          end else begin
            crlf_seen = (c == hcbd_pkg::MATCH_CR) ? hcbd_pkg::MATCH_CRLF
                                                  : hcbd_pkg::MATCH_NONE;
          end
        end else begin
          crlf_seen = hcbd_pkg::MATCH_NONE;
        end
      end
    endcase
    if (r.error_code != hcbd_pkg::ERR_NONE) sticky_err = r.error_code;
  endtask

  always @(posedge clk) begin : watch_channels
    deframe_result_t want;
    deframe_result_t got;
    if (!rst_n) begin
      trailers_on = 1'b0;
      sticky_err  = hcbd_pkg::ERR_NONE;
      rearm_parser();
      expected_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) trailers_on = cfg_trailers_enabled;
      if (in_valid && !in_stall) begin
        deframe_step(in_data_byte, want);
        expected_q.push_back(want);
      end
      if (out_valid && !out_stall) begin
        got = {out_byte_class, out_payload_byte, out_body_end, out_error_code};
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h", got));
        end else begin
          want = expected_q.pop_front();
          if (got.byte_class != want.byte_class)
            report_mismatch($sformatf("byte_class %0d, want %0d",
                                      got.byte_class, want.byte_class));
          if (got.payload_byte != want.payload_byte)
            report_mismatch($sformatf("payload_byte %h, want %h",
                                      got.payload_byte, want.payload_byte));
          if (got.body_end != want.body_end)
            report_mismatch($sformatf("body_end %b, want %b",
                                      got.body_end, want.body_end));
          if (got.error_code != want.error_code)
            report_mismatch($sformatf("error_code %0d, want %0d",
                                      got.error_code, want.error_code));
        end
      end
      if (end_check && expected_q.size() != 0) begin
        report_mismatch($sformatf("%0d results never arrived", expected_q.size()));
        expected_q.delete();
      end
    end
    pending_cnt <= expected_q.size();
  end

endmodule

// ===== tb/tb_http_chunked_body_deframer_core.sv =====
// Top of the chunked body deframer testbench: clock, reset, request stimulus,
// random back-pressure, watchdog and verdict. Checking is in hcbd_deframe_checker.
// Depends on hcbd_pkg, http_chunked_body_deframer_core and hcbd_deframe_checker.
`timescale 1ns / 1ps

module tb_http_chunked_body_deframer_core;

  localparam int unsigned IDLE_LIMIT = 3000;  // cycles with no handshake at all
  localparam int unsigned PHASE_LEN  = 460;   // requests per random phase

  // Ways to break the framing; any of them latches an error until reset,
  // so exactly one is used, at the very end of the run.
  typedef enum int unsigned {
    BRK_EMPTY_SEMI,
    BRK_EMPTY_CR,
    BRK_BAD_DIGIT,
    BRK_OVF_SHIFT,
    BRK_OVF_FULL,
    BRK_HDR_NO_LF,
    BRK_EXT_NO_LF,
    BRK_DATA_NO_CR,
    BRK_DATA_NO_LF
  } broken_kind_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_data_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [2:0] out_byte_class;
  logic [7:0] out_payload_byte;
  logic       out_body_end;
  logic [1:0] out_error_code;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_trailers_enabled = 1'b0;
  logic       end_check = 1'b0;

  int          pending_cnt;
  int          fail_count;
  int unsigned sent;
  int unsigned idle_cycles;
  bit          calm;    // no sender gaps and no result stalls
  bit          te_now;  // trailer mode currently programmed

  always #10 clk = ~clk;

  http_chunked_body_deframer_core i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_data_byte        (in_data_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_byte_class      (out_byte_class),
    .out_payload_byte    (out_payload_byte),
    .out_body_end        (out_body_end),
    .out_error_code      (out_error_code),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_trailers_enabled(cfg_trailers_enabled)
  );

  hcbd_deframe_checker i_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_data_byte        (in_data_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_byte_class      (out_byte_class),
    .out_payload_byte    (out_payload_byte),
    .out_body_end        (out_body_end),
    .out_error_code      (out_error_code),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_trailers_enabled(cfg_trailers_enabled),
    .end_check           (end_check),
    .pending_cnt         (pending_cnt),
    .fail_count          (fail_count)
  );

  // Gap before a request: mostly none or short, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned pick_stall_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 80);
  endfunction

  // Result-side back-pressure: open stretch, then a stall stretch (skipped
  // while calm). Each edge gets at most one assignment to out_stall.
  initial begin : stall_gen
    int unsigned n;
    forever begin
      n = $urandom_range(1, 12);
      out_stall <= 1'b0;
      repeat (n) @(posedge clk);
      n = pick_stall_len();
      if (!calm) out_stall <= 1'b1;
      repeat (n) @(posedge clk);
    end
  end

  // Watchdog: any handshake on any channel resets the count.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_http_chunked_body_deframer_core: errors");
        $finish;
      end
    end
  end

  // One byte request. in_valid stays high across back-to-back requests and
  // only drops when a gap is picked; the payload holds while stalled.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    do @(posedge clk); while (!(in_valid && !in_stall));
    sent++;
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_crlf();
    send_byte(hcbd_pkg::CHAR_CR);
    send_byte(hcbd_pkg::CHAR_LF);
  endtask

  // Chunk size in hex: random letter case and a few leading zeros.
  task automatic send_size(input int unsigned v);
    int unsigned nd;
    int unsigned d;
    nd = 1;
    while ((v >> (4 * nd)) != 0) nd++;
    repeat ($urandom_range(0, 2)) send_byte("0");
    for (int i = nd - 1; i >= 0; i--) begin
      d = (v >> (4 * i)) & 4'hf;
      if (d < 10) send_byte(8'("0" + d));
      else if ($urandom_range(0, 1) != 0) send_byte(8'("A" + d - 10));
      else send_byte(8'("a" + d - 10));
    end
  endtask

  // Optional extension: ';' plus arbitrary bytes, CR excluded since a CR
  // closes the header line.
  task automatic send_ext();
    logic [7:0] b;
    if ($urandom_range(0, 1) == 0) return;
    send_byte(hcbd_pkg::CHAR_SEMI);
    repeat ($urandom_range(0, 5)) begin
      b = $urandom_range(0, 255);
      send_byte(b == hcbd_pkg::CHAR_CR ? 8'h20 : b);
    end
  endtask

  // One trailer field line; LF alone is just noise inside the line.
  task automatic send_trailer_line();
    logic [7:0] b;
    repeat ($urandom_range(1, 8)) begin
      b = $urandom_range(0, 255);
      send_byte(b == hcbd_pkg::CHAR_CR ? 8'h3a : b);
    end
    send_crlf();
  endtask

  // A whole well-formed body: some data chunks, the last-chunk line and a
  // trailer shaped for the current trailer mode.
  task automatic send_body();
    int unsigned sz;
    int unsigned r;
    repeat ($urandom_range(0, 3)) begin
      r  = $urandom_range(0, 99);
      sz = (r < 85) ? $urandom_range(1, 16) :
           (r < 97) ? $urandom_range(17, 64) : $urandom_range(65, 300);
      send_size(sz);
      send_ext();
      send_crlf();
      repeat (sz) send_byte(8'($urandom_range(0, 255)));
      send_crlf();
    end
    send_size(0);
    send_ext();
    send_crlf();
    if (te_now) begin
      // field lines, then the empty line that ends the body
      repeat ($urandom_range(0, 2)) send_trailer_line();
      send_crlf();
    end else if ($urandom_range(0, 1) != 0) begin
      send_trailer_line();   // its CRLF already ends the body
    end else begin
      send_crlf();
    end
  endtask

  // Sender pauses until every predicted result has been taken.
  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_cnt != 0);
  endtask

  task automatic write_trailers(input logic v);
    wait_drain();
    cfg_valid            <= 1'b1;
    cfg_trailers_enabled <= v;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    te_now = v;
  endtask

  // Break the framing one way, then keep feeding noise: every later byte
  // must report the latched code.
  task automatic send_broken_tail();
    broken_kind_t kind;
    kind = broken_kind_t'($urandom_range(BRK_EMPTY_SEMI, BRK_DATA_NO_LF));
    case (kind)
      BRK_EMPTY_SEMI: send_str(";");
      BRK_EMPTY_CR:   send_str("\r");
      BRK_BAD_DIGIT:  send_str("5x");
      BRK_OVF_SHIFT:  send_str("100000000");
      BRK_OVF_FULL:   send_str("FFFFFFFFa");
      BRK_HDR_NO_LF:  send_str("3\rz");
      BRK_EXT_NO_LF:  send_str("2;ab\rq");
      BRK_DATA_NO_CR: send_str("1\r\n#x");
      default:        send_str("1\r\n#\ry");
    endcase
    repeat ($urandom_range(20, 40)) send_byte(8'($urandom_range(0, 255)));
  endtask

  initial begin : stimulus
    sent   = 0;
    calm   = 1'b0;
    te_now = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: leading zeros, extension marker, payload extremes, empty
    // trailer in both modes.
    write_trailers(1'b0);
    send_str("01;\r\n");
    send_byte(8'h00);
    send_str("\r\n1\r\n");
    send_byte(8'hff);
    send_str("\r\n0\r\n\r\n");
    write_trailers(1'b1);
    send_str("0\r\n\r\n");

    // Random bodies in phases; every phase boundary drains fully before the
    // register is rewritten. The third phase runs without gaps or stalls.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       write_trailers(1'b1);
        1:       write_trailers(1'b0);
        2:       write_trailers(1'b1);
        default: write_trailers(logic'($urandom_range(0, 1)));
      endcase
      calm = (ph == 2);
      while (sent < 24 + (ph + 1) * PHASE_LEN) send_body();
    end
    calm = 1'b0;

    send_broken_tail();

    wait_drain();
    repeat (8) @(posedge clk);
    end_check <= 1'b1;
    @(posedge clk);
    end_check <= 1'b0;
    @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_http_chunked_body_deframer_core: clean");
    end else begin
      $display("tb_http_chunked_body_deframer_core: errors");
    end
    $finish;
  end

endmodule
